// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file mlprq_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the reset is applied.
`define ASSERT_CLKRST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/mlprq_pkg.sv -----
`default_nettype none

package mlprq_pkg;

  localparam int unsigned LEVELS_DEF      = 16;
  localparam int unsigned LEVEL_DEPTH_DEF = 16;

  localparam int unsigned HandleW = 16;
  localparam int unsigned PrioW   = 4;
  localparam int unsigned StatusW = 2;

  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd2;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

endpackage

`default_nettype wire

// ----- hw/rtl/multilevel_priority_ready_queue.sv -----
// Channel   | Direction | Signals                                         | Handshake
// ----------+-----------+-------------------------------------------------+-------------------
// command   | in        | func_i, task_priority_i, task_handle_i          | start_i && !busy_o
// result    | out       | out_handle_o, out_priority_o, status_o          | done_o, one cycle
//
// A refused enqueue or a dequeue on an empty queue goes from S_IDLE straight to
// S_RESP; an accepted enqueue passes through S_PTR and a dequeue through S_PTR
// and S_MEM, which wait on the registered reads of the pointer memory and, for
// a dequeue, of the entry memory. The result is shown for one cycle with
// done_o, after which busy_o falls. Reset empties every level at once through
// per-level valid bits on the pointer memory. The receiver cannot stall.
`default_nettype none

module multilevel_priority_ready_queue
  import mlprq_pkg::*;
#(
  parameter int unsigned LEVELS      = LEVELS_DEF,
  parameter int unsigned LEVEL_DEPTH = LEVEL_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic               func_i,
  input  wire logic [PrioW-1:0]   task_priority_i,
  input  wire logic [HandleW-1:0] task_handle_i,
  output logic                    done_o,
  output logic [HandleW-1:0]      out_handle_o,
  output logic [PrioW-1:0]        out_priority_o,
  output logic [StatusW-1:0]      status_o
);

  localparam int unsigned LW = $clog2(LEVELS);
  localparam int unsigned PW = $clog2(LEVEL_DEPTH);
  localparam int unsigned CW = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned EntryDepth = LEVELS * LEVEL_DEPTH;
  localparam int unsigned AW = $clog2(EntryDepth);

  typedef struct packed {
    logic [PW-1:0] head;
    logic [PW-1:0] tail;
    logic [CW-1:0] count;
  } ptr_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PTR  = 4'b0010,
    S_MEM  = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic               func_q;
  logic [LW-1:0]      lvl_q, lvl_d;
  logic [HandleW-1:0] handle_q;
  logic [HandleW-1:0] res_handle_q, res_handle_d;
  logic [PrioW-1:0]   res_prio_q, res_prio_d;
  logic [StatusW-1:0] res_status_q, res_status_d;

  logic [LEVELS-1:0]  nonempty_q, nonempty_d;
  logic [LEVELS-1:0]  full_q, full_d;
  logic [LEVELS-1:0]  ptr_vld_q, ptr_vld_d;

  // Pointer memory: head, tail and fill count for each level.
  ptr_t               ptr_mem [LEVELS];
  ptr_t               ptr_rd_q;
  logic               ptr_rd_vld_q;
  logic [LW-1:0]      ptr_raddr;
  logic               ptr_re;
  logic               ptr_we;
  ptr_t               ptr_wdata;
  ptr_t               ptr_cur;

  // Entry memory: one row of LEVEL_DEPTH handles for each level.
  logic [HandleW-1:0] ent_mem [EntryDepth];
  logic [HandleW-1:0] ent_rd_q;
  logic [AW-1:0]      ent_addr;
  logic               ent_we;
  logic               ent_re;

  logic               accept;
  logic               deq_found;
  logic [LW-1:0]      deq_lvl;
  logic [LW-1:0]      enq_lvl;
  logic               enq_oob;
  logic [PW-1:0]      slot;
  logic [PW-1:0]      slot_next;

  assign accept = start_i && (state_q == S_IDLE);

  always_comb begin
    deq_found = 1'b0;
    deq_lvl   = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty_q[i]) begin
        deq_found = 1'b1;
        deq_lvl   = LW'(i);
      end
    end
  end

  assign enq_oob = (32'(task_priority_i) >= 32'(LEVELS));
  assign enq_lvl = LW'(task_priority_i);

  assign ptr_cur   = ptr_rd_vld_q ? ptr_rd_q : '0;
  assign slot      = (func_q == FUNC_ENQ) ? ptr_cur.tail : ptr_cur.head;
  assign slot_next = (slot == PW'(LEVEL_DEPTH - 1)) ? '0 : slot + 1'b1;
  assign ent_addr  = AW'(lvl_q) * AW'(LEVEL_DEPTH) + AW'(slot);

  always_comb begin
    state_d      = state_q;
    lvl_d        = lvl_q;
    res_handle_d = res_handle_q;
    res_prio_d   = res_prio_q;
    res_status_d = res_status_q;
    nonempty_d   = nonempty_q;
    full_d       = full_q;
    ptr_vld_d    = ptr_vld_q;
    ptr_re       = 1'b0;
    ptr_raddr    = '0;
    ptr_we       = 1'b0;
    ptr_wdata    = ptr_cur;
    ent_we       = 1'b0;
    ent_re       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_handle_d = '0;
          res_prio_d   = '0;
          res_status_d = ST_OK;
          if (func_i == FUNC_ENQ) begin
            lvl_d = enq_lvl;
            if (enq_oob || full_q[enq_lvl]) begin
              res_status_d = ST_FULL;
              state_d      = S_RESP;
            end else begin
              ptr_re    = 1'b1;
              ptr_raddr = enq_lvl;
              state_d   = S_PTR;
            end
          end else begin
            lvl_d = deq_lvl;
            if (!deq_found) begin
              res_status_d = ST_EMPTY;
              state_d      = S_RESP;
            end else begin
              ptr_re    = 1'b1;
              ptr_raddr = deq_lvl;
              state_d   = S_PTR;
            end
          end
        end
      end
      S_PTR: begin
        ptr_we           = 1'b1;
        ptr_vld_d[lvl_q] = 1'b1;
        if (func_q == FUNC_ENQ) begin
          ent_we              = 1'b1;
          ptr_wdata.tail      = slot_next;
          ptr_wdata.count     = ptr_cur.count + 1'b1;
          nonempty_d[lvl_q]   = 1'b1;
          full_d[lvl_q]       = (ptr_wdata.count == CW'(LEVEL_DEPTH));
          state_d             = S_RESP;
        end else begin
          ent_re              = 1'b1;
          ptr_wdata.head      = slot_next;
          ptr_wdata.count     = ptr_cur.count - 1'b1;
          full_d[lvl_q]       = 1'b0;
          nonempty_d[lvl_q]   = (ptr_wdata.count != '0);
          res_prio_d          = PrioW'(lvl_q);
          state_d             = S_MEM;
        end
      end
      S_MEM: begin
        res_handle_d = ent_rd_q;
        state_d      = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      nonempty_q <= '0;
      full_q     <= '0;
      ptr_vld_q  <= '0;
    end else begin
      state_q    <= state_d;
      nonempty_q <= nonempty_d;
      full_q     <= full_d;
      ptr_vld_q  <= ptr_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q   <= func_i;
      handle_q <= task_handle_i;
    end
    lvl_q        <= lvl_d;
    res_handle_q <= res_handle_d;
    res_prio_q   <= res_prio_d;
    res_status_q <= res_status_d;
  end

  always_ff @(posedge clk_i) begin
    if (ptr_we) begin
      ptr_mem[lvl_q] <= ptr_wdata;
    end
    if (ptr_re) begin
      ptr_rd_q     <= ptr_mem[ptr_raddr];
      ptr_rd_vld_q <= ptr_vld_q[ptr_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_addr] <= handle_q;
    end
    if (ent_re) begin
      ent_rd_q <= ent_mem[ent_addr];
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = (state_q == S_RESP);
  assign out_handle_o   = res_handle_q;
  assign out_priority_o = res_prio_q;
  assign status_o       = res_status_q;

endmodule

`default_nettype wire

// ----- hw/rtl/mlprq_checker.sv -----
`default_nettype none

`include "assert_macros.svh"

module mlprq_checker
  import mlprq_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start_i,
  input wire logic               busy_o,
  input wire logic               done_o,
  input wire logic [HandleW-1:0] out_handle_o,
  input wire logic [PrioW-1:0]   out_priority_o,
  input wire logic [StatusW-1:0] status_o
);

  // A transaction that is taken always keeps the block busy in the next cycle.
  `ASSERT_CLKRST(a_accept_busy, clk_i, rst_ni, (start_i && !busy_o) |=> busy_o, "accept without busy")

  // A result only appears while a transaction is in flight.
  `ASSERT_CLK(a_done_busy, clk_i, done_o |-> busy_o, "result while idle")

  // After its result the block is free again.
  `ASSERT_CLKRST(a_done_idle, clk_i, rst_ni, done_o |=> !busy_o, "busy after result")

  // Failed transactions carry neither a handle nor a level.
  `ASSERT_CLKRST(a_fail_zero, clk_i, rst_ni, (done_o && status_o != ST_OK) |-> (out_handle_o == '0 && out_priority_o == '0), "payload on failure")

endmodule

bind multilevel_priority_ready_queue mlprq_checker u_mlprq_checker (.*);

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import mlprq_pkg::*;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned RandomItems = 1150;

  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic [PrioW-1:0]   prio;
    logic [StatusW-1:0] status;
  } ready_result_t;

  // Strict-priority queue predictor plus the list of results still owed by the block.
  class ready_queue_scoreboard;
    logic [HandleW-1:0] slots [LEVELS_DEF][LEVEL_DEPTH_DEF];
    int unsigned        head_slot [LEVELS_DEF];
    int unsigned        tail_slot [LEVELS_DEF];
    int unsigned        occupancy [LEVELS_DEF];
    ready_result_t      owed [$];
    int unsigned        mismatches;

    function new();
      mismatches = 0;
      for (int lv = 0; lv < LEVELS_DEF; lv++) begin
        head_slot[lv] = 0;
        tail_slot[lv] = 0;
        occupancy[lv] = 0;
      end
    endfunction

    function void note_command(logic f, logic [PrioW-1:0] p, logic [HandleW-1:0] h);
      ready_result_t r;
      bit            found;
      int unsigned   lv;
      r = '0;
      r.status = ST_OK;
      if (f == FUNC_ENQ) begin
        if (p >= LEVELS_DEF || occupancy[p] >= LEVEL_DEPTH_DEF) begin
          r.status = ST_FULL;
        end else begin
          slots[p][tail_slot[p]] = h;
          tail_slot[p] = (tail_slot[p] + 1) % LEVEL_DEPTH_DEF;
          occupancy[p]++;
        end
      end else begin
        found = 1'b0;
        for (lv = 0; lv < LEVELS_DEF; lv++) begin
          if (!found && occupancy[lv] != 0) begin
            found = 1'b1;
            r.handle = slots[lv][head_slot[lv]];
            r.prio = lv[PrioW-1:0];
            head_slot[lv] = (head_slot[lv] + 1) % LEVEL_DEPTH_DEF;
            occupancy[lv]--;
          end
        end
        if (!found) begin
          r.status = ST_EMPTY;
        end
      end
      owed.push_back(r);
    endfunction

    function void check_result(logic [HandleW-1:0] h, logic [PrioW-1:0] p,
                               logic [StatusW-1:0] s);
      ready_result_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: handle %h prio %0d status %0d", h, p, s);
        end
      end else begin
        want = owed.pop_front();
        if (h !== want.handle || p !== want.prio || s !== want.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected handle %h prio %0d status %0d, got %h %0d %0d",
                     want.handle, want.prio, want.status, h, p, s);
          end
        end
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic               func_i;
  logic [PrioW-1:0]   task_priority_i;
  logic [HandleW-1:0] task_handle_i;
  logic               done_o;
  logic [HandleW-1:0] out_handle_o;
  logic [PrioW-1:0]   out_priority_o;
  logic [StatusW-1:0] status_o;

  ready_queue_scoreboard sb = new();

  int unsigned burst_left;
  int unsigned stall_cycles;

  multilevel_priority_ready_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .func_i         (func_i),
    .task_priority_i(task_priority_i),
    .task_handle_i  (task_handle_i),
    .done_o         (done_o),
    .out_handle_o   (out_handle_o),
    .out_priority_o (out_priority_o),
    .status_o       (status_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Results are checked before the new transaction is noted, so ordering stays intact.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        sb.check_result(out_handle_o, out_priority_o, status_o);
      end
      if (start_i && !busy_o) begin
        sb.note_command(func_i, task_priority_i, task_handle_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic idle_gap(input int unsigned cycles);
    start_i <= 1'b0;
    func_i <= 1'($urandom);
    task_priority_i <= PrioW'($urandom);
    task_handle_i <= HandleW'($urandom);
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic send_cmd(input logic f, input logic [PrioW-1:0] p,
                          input logic [HandleW-1:0] h);
    if (burst_left == 0) begin
      idle_gap(($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 4));
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 120)
                                                : $urandom_range(1, 12);
    end
    start_i <= 1'b1;
    func_i <= f;
    task_priority_i <= p;
    task_handle_i <= h;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    burst_left--;
  endtask

  // Waits for a clock edge before polling, so that the transaction taken at the last edge has been noted.
  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.owed.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase_len;
    int unsigned mode;
    int unsigned enq_pct;
    logic [PrioW-1:0] base_prio;
    logic [PrioW-1:0] prio;
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    func_i <= FUNC_ENQ;
    task_priority_i <= '0;
    task_handle_i <= '0;
    burst_left = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty queue, extreme handles and levels, then a single level filled past its depth.
    send_cmd(FUNC_DEQ, '0, '0);
    send_cmd(FUNC_ENQ, 4'd15, 16'hFFFF);
    send_cmd(FUNC_ENQ, 4'd0, 16'h0000);
    send_cmd(FUNC_ENQ, 4'd15, 16'h5AA5);
    send_cmd(FUNC_DEQ, 4'd15, 16'hFFFF);
    send_cmd(FUNC_DEQ, '0, '0);
    send_cmd(FUNC_DEQ, '0, '0);
    send_cmd(FUNC_DEQ, '0, '0);
    for (int i = 0; i <= LEVEL_DEPTH_DEF; i++) begin
      send_cmd(FUNC_ENQ, 4'd7, HandleW'($urandom));
    end
    wait_drained();

    // Random phases: filling bursts on a few levels, draining bursts and mixed traffic.
    sent = 0;
    while (sent < RandomItems) begin
      phase_len = $urandom_range(20, 80);
      mode = $urandom_range(0, 2);
      enq_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
      base_prio = PrioW'($urandom);
      for (int i = 0; i < phase_len; i++) begin
        if (mode == 0) begin
          prio = base_prio + PrioW'($urandom_range(0, 1));
        end else begin
          prio = PrioW'($urandom);
        end
        if ($urandom_range(0, 99) < enq_pct) begin
          send_cmd(FUNC_ENQ, prio, HandleW'($urandom));
        end else begin
          send_cmd(FUNC_DEQ, prio, HandleW'($urandom));
        end
        sent++;
      end
      if ($urandom_range(0, 4) == 0) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- multilevel_priority_ready_queue.f -----
+incdir+hw/rtl
hw/rtl/mlprq_pkg.sv
hw/rtl/multilevel_priority_ready_queue.sv
hw/rtl/mlprq_checker.sv
bench/tb_top.sv
